@@ design/bsm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_pkg
// Types and constants shared by the bank switch mapper core and its bank file.
// ----------------------------------------------------------------------------
package bsm_pkg;

   // Request kinds
   typedef enum logic [1:0] {
      MODE_CPU  = 2'd0,
      MODE_PPU  = 2'd1,
      MODE_TICK = 2'd2,
      MODE_ACK  = 2'd3
   } mode_type;

   // Result targets
   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_SRAM = 2'd1,
      TGT_PRG  = 2'd2,
      TGT_CHR  = 2'd3
   } target_type;

   // Mapper register groups, address bits 14:13
   typedef enum logic [1:0] {
      GRP_BANK   = 2'd0,
      GRP_MIRROR = 2'd1,
      GRP_LATCH  = 2'd2,
      GRP_IRQ    = 2'd3
   } group_type;

   // Configuration register indexes
   typedef enum logic [0:0] {
      CSR_PRG_BLOCKS = 1'b0,
      CSR_CHR_BLOCKS = 1'b1
   } csr_index_type;

   localparam logic [7:0] PRG_BLOCKS_RESET = 8'd32;
   localparam logic [7:0] CHR_BLOCKS_RESET = 8'd0;

   localparam int PRG_SLOTS = 4;
   localparam int CHR_SLOTS = 8;

   typedef logic [CHR_SLOTS-1:0][7:0] chr_slots_type;
   typedef logic [PRG_SLOTS-1:0][8:0] prg_slots_type;

   // Commands from the register decode to the bank file
   typedef struct packed {
      logic       select_write;
      logic       data_write;
      logic [7:0] data;
   } bank_cmd_type;

endpackage

@@ design/bank_switch_mapper_scanline_irq_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_core
// Bank switching mapper: address translation, mapper registers and the
// scanline interrupt counter.
// ----------------------------------------------------------------------------
//  channel | direction | ports                          | handshake
//  req     | in        | mode, is_write, address, data  | req_valid / req_stall
//  rsp     | out       | target, mem_address, flags     | rsp_valid / rsp_stall
//  csr     | in        | index, wdata                   | csr_write, no wait
//
//  Decode, slot lookup and state update happen at the accepting edge, and
//  the result lands in the output register.
//  A new request is taken every cycle while the output register is free or
//  being emptied; req_stall is high only while a result is held by rsp_stall.
//  Synchronous reset clears all mapper state; no clearing pass.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_core
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_is_write,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_target,
   output logic [21:0] rsp_mem_address,
   output logic        rsp_mem_write,
   output logic        rsp_handled,
   output logic        rsp_mirror_vertical,
   output logic        rsp_irq_line,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   logic          req_accept;
   mode_type      mode;
   group_type     group;
   logic          odd;
   logic          reg_write;
   bank_cmd_type  bank_cmd;
   chr_slots_type chr_slots;
   prg_slots_type prg_slots;
   logic [8:0]    prg_bank;
   logic [7:0]    chr_bank;

   logic [7:0]    prg_blocks_ff;
   logic [7:0]    chr_blocks_ff;
   logic          mirror_ff, mirror_in;
   logic          irq_enable_ff, irq_enable_in;
   logic          irq_pending_ff, irq_pending_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    latch_ff, latch_in;

   logic          rsp_valid_ff;
   target_type    target_ff, target_in;
   logic [21:0]   mem_address_ff, mem_address_in;
   logic          mem_write_ff, mem_write_in;
   logic          handled_ff, handled_in;
   logic          mirror_out_ff;
   logic          irq_out_ff;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   assign mode      = mode_type'(req_mode);
   assign group     = group_type'(req_address[14:13]);
   assign odd       = req_address[0];
   assign reg_write = (mode == MODE_CPU) & req_address[15] & req_is_write;

   assign bank_cmd.select_write = req_accept & reg_write & (group == GRP_BANK) & ~odd;
   assign bank_cmd.data_write   = req_accept & reg_write & (group == GRP_BANK) & odd;
   assign bank_cmd.data         = req_write_data;

   bsm_banks u_banks (
      .clock          (clock),
      .reset          (reset),
      .cmd            (bank_cmd),
      .prg_rom_blocks (prg_blocks_ff),
      .chr_slots      (chr_slots),
      .prg_slots      (prg_slots)
   );

   assign prg_bank = prg_slots[req_address[14:13]];
   assign chr_bank = chr_slots[req_address[12:10]];

   always_comb begin
      target_in      = TGT_NONE;
      mem_address_in = '0;
      mem_write_in   = 1'b0;
      handled_in     = 1'b1;
      mirror_in      = mirror_ff;
      irq_enable_in  = irq_enable_ff;
      irq_pending_in = irq_pending_ff;
      count_in       = count_ff;
      latch_in       = latch_ff;
      unique case (mode)
         MODE_CPU: begin
            if (!req_address[15]) begin
               target_in      = TGT_SRAM;
               mem_address_in = {9'd0, req_address[12:0]};
               mem_write_in   = req_is_write;
            end else if (req_is_write) begin
               unique case (group)
                  GRP_BANK: ;   // handled in the bank file
                  GRP_MIRROR: begin
                     if (!odd) begin
                        mirror_in = ~req_write_data[0];
                     end
                  end
                  GRP_LATCH: begin
                     if (odd) begin
                        count_in = '0;
                     end else begin
                        latch_in = req_write_data;
                     end
                  end
                  GRP_IRQ: begin
                     if (odd) begin
                        irq_enable_in = 1'b1;
                     end else begin
                        irq_enable_in  = 1'b0;
                        irq_pending_in = 1'b0;
                     end
                  end
                  default: ;
               endcase
            end else begin
               target_in      = TGT_PRG;
               mem_address_in = {prg_bank, req_address[12:0]};
            end
         end
         MODE_PPU: begin
            if (!req_is_write || chr_blocks_ff == 8'd0) begin
               target_in      = TGT_CHR;
               mem_address_in = {4'd0, chr_bank, req_address[9:0]};
               mem_write_in   = req_is_write;
            end else begin
               handled_in = 1'b0;   // pattern ROM is read only
            end
         end
         MODE_TICK: begin
            count_in = (count_ff == 8'd0) ? latch_ff : count_ff - 8'd1;
            if (count_in == 8'd0 && irq_enable_ff) begin
               irq_pending_in = 1'b1;
            end
         end
         MODE_ACK: begin
            irq_pending_in = 1'b0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_blocks_ff  <= PRG_BLOCKS_RESET;
         chr_blocks_ff  <= CHR_BLOCKS_RESET;
         mirror_ff      <= 1'b0;
         irq_enable_ff  <= 1'b0;
         irq_pending_ff <= 1'b0;
         count_ff       <= '0;
         latch_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index_type'(csr_index))
               CSR_PRG_BLOCKS: prg_blocks_ff <= csr_wdata;
               CSR_CHR_BLOCKS: chr_blocks_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (req_accept) begin
            mirror_ff      <= mirror_in;
            irq_enable_ff  <= irq_enable_in;
            irq_pending_ff <= irq_pending_in;
            count_ff       <= count_in;
            latch_ff       <= latch_in;
            rsp_valid_ff   <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff   <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         target_ff      <= target_in;
         mem_address_ff <= mem_address_in;
         mem_write_ff   <= mem_write_in;
         handled_ff     <= handled_in;
         mirror_out_ff  <= mirror_in;
         irq_out_ff     <= irq_pending_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_target          = target_ff;
   assign rsp_mem_address     = mem_address_ff;
   assign rsp_mem_write       = mem_write_ff;
   assign rsp_handled         = handled_ff;
   assign rsp_mirror_vertical = mirror_out_ff;
   assign rsp_irq_line        = irq_out_ff;

   // acknowledge always leaves the line low
   a_ack_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && mode == MODE_ACK |=> !rsp_irq_line)
      else $error("irq line high after acknowledge");

   // refused pattern write only when ROM is fitted
   a_refuse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_handled |-> rsp_target == TGT_NONE && !rsp_mem_write
                                    && chr_blocks_ff != 8'd0)
      else $error("bad refused request");

   // no memory address on internal results
   a_none_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target == TGT_NONE |-> rsp_mem_address == 22'd0 && !rsp_mem_write)
      else $error("address on internal result");

   // an accepted request always produces a result next cycle
   a_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("result lost");

   // pending interrupt follows the result line
   a_irq_track: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_irq_line == irq_pending_ff)
      else $error("irq line out of step");

endmodule

@@ design/bsm_banks.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsm_banks
// Bank select and bank data registers, and the program and pattern slot tables
// rebuilt on every bank data write.
// ----------------------------------------------------------------------------
module bsm_banks
   import bsm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  bank_cmd_type  cmd,
   input  logic [7:0]    prg_rom_blocks,
   output chr_slots_type chr_slots,
   output prg_slots_type prg_slots
);

   logic [2:0]          select_ff;
   logic                prg_swap_ff;
   logic                chr_invert_ff;
   logic [7:0][7:0]     values_ff;
   logic [7:0][7:0]     values_in;
   chr_slots_type       chr_slots_ff;
   chr_slots_type       chr_slots_in;
   prg_slots_type       prg_slots_ff;
   prg_slots_type       prg_slots_in;
   logic [8:0]          two_n;
   logic [8:0]          last_but_one;
   logic [8:0]          last_bank;
   logic [7:0]          pair0;
   logic [7:0]          pair1;

   assign two_n        = {prg_rom_blocks, 1'b0};
   assign last_but_one = two_n - 9'd2;   // wraps modulo 512 for zero blocks
   assign last_bank    = two_n - 9'd1;

   always_comb begin
      values_in = values_ff;
      if (cmd.data_write) begin
         values_in[select_ff] = cmd.data;
      end
      pair0 = values_in[0] & 8'hFE;
      pair1 = values_in[1] & 8'hFE;
      if (chr_invert_ff) begin
         chr_slots_in[4] = pair0;
         chr_slots_in[5] = pair0 + 8'd1;
         chr_slots_in[6] = pair1;
         chr_slots_in[7] = pair1 + 8'd1;
         chr_slots_in[0] = values_in[2];
         chr_slots_in[1] = values_in[3];
         chr_slots_in[2] = values_in[4];
         chr_slots_in[3] = values_in[5];
      end else begin
         chr_slots_in[0] = pair0;
         chr_slots_in[1] = pair0 + 8'd1;
         chr_slots_in[2] = pair1;
         chr_slots_in[3] = pair1 + 8'd1;
         chr_slots_in[4] = values_in[2];
         chr_slots_in[5] = values_in[3];
         chr_slots_in[6] = values_in[4];
         chr_slots_in[7] = values_in[5];
      end
      if (prg_swap_ff) begin
         prg_slots_in[2] = {3'd0, values_in[6][5:0]};
         prg_slots_in[0] = last_but_one;
      end else begin
         prg_slots_in[0] = {3'd0, values_in[6][5:0]};
         prg_slots_in[2] = last_but_one;
      end
      prg_slots_in[1] = {3'd0, values_in[7][5:0]};
      prg_slots_in[3] = last_bank;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         select_ff     <= '0;
         prg_swap_ff   <= 1'b0;
         chr_invert_ff <= 1'b0;
         values_ff     <= '0;
         chr_slots_ff  <= '0;
         // fixed slots from the reset block count
         prg_slots_ff[0] <= 9'd0;
         prg_slots_ff[1] <= 9'd1;
         prg_slots_ff[2] <= {PRG_BLOCKS_RESET, 1'b0} - 9'd2;
         prg_slots_ff[3] <= {PRG_BLOCKS_RESET, 1'b0} - 9'd1;
      end else begin
         if (cmd.select_write) begin
            select_ff     <= cmd.data[2:0];
            prg_swap_ff   <= cmd.data[6];
            chr_invert_ff <= cmd.data[7];
         end
         if (cmd.data_write) begin
            values_ff    <= values_in;
            chr_slots_ff <= chr_slots_in;
            prg_slots_ff <= prg_slots_in;
         end
      end
   end

   assign chr_slots = chr_slots_ff;
   assign prg_slots = prg_slots_ff;

endmodule

@@ tb/sv/bank_switch_mapper_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_checker
// Watches the request, result and CSR ports of the mapper core. Keeps its own
// copy of the bank tables, mirroring and scanline IRQ state, works out the
// translation for each accepted request and compares every accepted result
// with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module bank_switch_mapper_checker
   import bsm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic        req_is_write,
   input  logic [15:0] req_address,
   input  logic [7:0]  req_write_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_target,
   input  logic [21:0] rsp_mem_address,
   input  logic        rsp_mem_write,
   input  logic        rsp_handled,
   input  logic        rsp_mirror_vertical,
   input  logic        rsp_irq_line,
   input  logic        csr_write,
   input  logic [0:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      target_type  target;
      logic [21:0] mem_address;
      logic        mem_write;
      logic        handled;
      logic        mirror_vertical;
      logic        irq_line;
   } translation_type;

   // configuration copy
   logic [7:0] prg_blocks;
   logic [7:0] chr_blocks;

   // mapper state copy
   logic [2:0]    bank_select;
   logic          prg_swap;
   logic          chr_invert;
   logic [7:0]    bank_regs [8];
   chr_slots_type chr_slots;
   prg_slots_type prg_slots;
   logic          mirror_vert;
   logic          irq_armed;
   logic          irq_pending;
   logic [7:0]    scan_count;
   logic [7:0]    scan_latch;

   translation_type expected_translations[$];

   function automatic logic [8:0] prg_last_bank();
      return {prg_blocks, 1'b0} - 9'd1;
   endfunction

   function automatic logic [8:0] prg_second_last_bank();
      return {prg_blocks, 1'b0} - 9'd2;
   endfunction

   function automatic void clear_mapper();
      prg_blocks  = PRG_BLOCKS_RESET;
      chr_blocks  = CHR_BLOCKS_RESET;
      bank_select = '0;
      prg_swap    = 1'b0;
      chr_invert  = 1'b0;
      for (int k = 0; k < 8; k++) bank_regs[k] = '0;
      chr_slots    = '0;
      prg_slots[0] = 9'd0;
      prg_slots[1] = 9'd1;
      prg_slots[2] = prg_second_last_bank();
      prg_slots[3] = prg_last_bank();
      mirror_vert  = 1'b0;
      irq_armed    = 1'b0;
      irq_pending  = 1'b0;
      scan_count   = '0;
      scan_latch   = '0;
   endfunction

   function automatic void rebuild_banks();
      logic [7:0] pair0;
      logic [7:0] pair1;
      logic [2:0] lo;
      logic [2:0] hi;
      pair0 = bank_regs[0] & 8'hFE;
      pair1 = bank_regs[1] & 8'hFE;
      lo    = chr_invert ? 3'd4 : 3'd0;
      hi    = chr_invert ? 3'd0 : 3'd4;
      chr_slots[lo]        = pair0;
      chr_slots[lo + 3'd1] = pair0 + 8'd1;
      chr_slots[lo + 3'd2] = pair1;
      chr_slots[lo + 3'd3] = pair1 + 8'd1;
      for (int k = 0; k < 4; k++) chr_slots[hi + 3'(k)] = bank_regs[3'(2 + k)];
      if (prg_swap) begin
         prg_slots[2] = {3'b000, bank_regs[6][5:0]};
         prg_slots[0] = prg_second_last_bank();
      end else begin
         prg_slots[0] = {3'b000, bank_regs[6][5:0]};
         prg_slots[2] = prg_second_last_bank();
      end
      prg_slots[1] = {3'b000, bank_regs[7][5:0]};
      prg_slots[3] = prg_last_bank();
   endfunction

   function automatic void write_mapper_reg(logic [15:0] addr, logic [7:0] data);
      logic odd;
      odd = addr[0];
      case (group_type'(addr[14:13]))
         GRP_BANK: begin
            if (!odd) begin
               bank_select = data[2:0];
               prg_swap    = data[6];
               chr_invert  = data[7];
            end else begin
               bank_regs[bank_select] = data;
               rebuild_banks();
            end
         end
         GRP_MIRROR: begin
            if (!odd) mirror_vert = ~data[0];
         end
         GRP_LATCH: begin
            if (!odd) scan_latch = data;
            else scan_count = '0;
         end
         default: begin
            if (!odd) begin
               irq_armed   = 1'b0;
               irq_pending = 1'b0;
            end else begin
               irq_armed = 1'b1;
            end
         end
      endcase
   endfunction

   function automatic translation_type translate_request(mode_type mode, logic wr,
                                                          logic [15:0] addr, logic [7:0] data);
      translation_type t;
      logic [7:0]      chr_bank;
      t.target      = TGT_NONE;
      t.mem_address = '0;
      t.mem_write   = 1'b0;
      t.handled     = 1'b1;
      case (mode)
         MODE_CPU: begin
            if (!addr[15]) begin
               t.target      = TGT_SRAM;
               t.mem_address = {9'd0, addr[12:0]};
               t.mem_write   = wr;
            end else if (wr) begin
               write_mapper_reg(addr, data);
            end else begin
               t.target      = TGT_PRG;
               t.mem_address = {prg_slots[addr[14:13]], addr[12:0]};
            end
         end
         MODE_PPU: begin
            chr_bank = chr_slots[addr[12:10]];
            if (!wr) begin
               t.target      = TGT_CHR;
               t.mem_address = {4'd0, chr_bank, addr[9:0]};
            end else if (chr_blocks == 8'd0) begin
               t.target      = TGT_CHR;
               t.mem_address = {4'd0, chr_bank, addr[9:0]};
               t.mem_write   = 1'b1;
            end else begin
               t.handled = 1'b0;   // pattern ROM refuses writes
            end
         end
         MODE_TICK: begin
            if (scan_count == 8'd0) scan_count = scan_latch;
            else scan_count = scan_count - 8'd1;
            if (scan_count == 8'd0 && irq_armed) irq_pending = 1'b1;
         end
         default: irq_pending = 1'b0;
      endcase
      t.mirror_vertical = mirror_vert;
      t.irq_line        = irq_pending;
      return t;
   endfunction

   function automatic void check_field(string name, logic [21:0] want, logic [21:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      translation_type want;
      if (reset) begin
         clear_mapper();
         expected_translations.delete();
         errors = 0;
      end else begin
         if (csr_write) begin
            if (csr_index == CSR_PRG_BLOCKS) prg_blocks = csr_wdata;
            else chr_blocks = csr_wdata;
         end
         // result leaving this edge belongs to an earlier request
         if (rsp_valid && !rsp_stall) begin
            if (expected_translations.size() == 0) begin
               $display("%0t ns: result with no request outstanding, expected none, actual 0x%0h",
                        $time, rsp_mem_address);
               errors++;
            end else begin
               want = expected_translations.pop_front();
               check_field("target", 22'(want.target), 22'(rsp_target));
               check_field("mem_address", want.mem_address, rsp_mem_address);
               check_field("mem_write", 22'(want.mem_write), 22'(rsp_mem_write));
               check_field("handled", 22'(want.handled), 22'(rsp_handled));
               check_field("mirror_vertical", 22'(want.mirror_vertical),
                           22'(rsp_mirror_vertical));
               check_field("irq_line", 22'(want.irq_line), 22'(rsp_irq_line));
            end
         end
         if (req_valid && !req_stall)
            expected_translations.push_back(translate_request(mode_type'(req_mode),
               req_is_write, req_address, req_write_data));
      end
      pending = expected_translations.size();
   end

endmodule

@@ tb/sv/bank_switch_mapper_scanline_irq_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bank_switch_mapper_scanline_irq_core_tb
// Drives CPU, PPU, scanline tick and IRQ acknowledge requests into the mapper
// core across several block-count settings, with random gaps and back
// pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module bank_switch_mapper_scanline_irq_core_tb;
   import bsm_pkg::*;

   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 160;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PRESSURE_AT     = 300;
   localparam int PRESSURE_CYCLES = 80;
   localparam int WATCHDOG_LIMIT  = 2000;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [1:0]  req_mode       = MODE_CPU;
   logic        req_is_write   = 1'b0;
   logic [15:0] req_address    = '0;
   logic [7:0]  req_write_data = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_target;
   logic [21:0] rsp_mem_address;
   logic        rsp_mem_write;
   logic        rsp_handled;
   logic        rsp_mirror_vertical;
   logic        rsp_irq_line;
   logic        csr_write      = 1'b0;
   logic [0:0]  csr_index      = CSR_PRG_BLOCKS;
   logic [7:0]  csr_wdata      = '0;

   int check_errors;
   int check_pending;
   int sent_count    = 0;
   int quiet_cycles  = 0;
   bit calm          = 1'b0;
   bit hold_on       = 1'b0;
   bit pressure_done = 1'b0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   bank_switch_mapper_scanline_irq_core u_top (.*);

   bank_switch_mapper_checker u_checker (
      .clock, .reset,
      .req_valid, .req_stall, .req_mode, .req_is_write, .req_address, .req_write_data,
      .rsp_valid, .rsp_stall, .rsp_target, .rsp_mem_address, .rsp_mem_write,
      .rsp_handled, .rsp_mirror_vertical, .rsp_irq_line,
      .csr_write, .csr_index, .csr_wdata,
      .errors (check_errors),
      .pending(check_pending)
   );

   // called at a rising edge; returns at the edge that took the request
   task automatic send_item(mode_type mode, logic wr, logic [15:0] addr, logic [7:0] data);
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_is_write   <= wr;
      req_address    <= addr;
      req_write_data <= data;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      sent_count++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (check_pending != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(logic [7:0] prg, logic [7:0] chr);
      csr_write <= 1'b1;
      csr_index <= CSR_PRG_BLOCKS;
      csr_wdata <= prg;
      @(posedge clock);
      csr_index <= CSR_CHR_BLOCKS;
      csr_wdata <= chr;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(MODE_CPU, 1'b0, 16'h0000, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'h7FFF, 8'hFF);
      send_item(MODE_CPU, 1'b0, 16'h8000, 8'h00);
      send_item(MODE_CPU, 1'b0, 16'hFFFF, 8'h00);
      // bank 6 with program swap, then chr inversion with bank 0
      send_item(MODE_CPU, 1'b1, 16'h8000, 8'h46);
      send_item(MODE_CPU, 1'b1, 16'h8001, 8'hFF);
      send_item(MODE_CPU, 1'b0, 16'h8000, 8'h00);
      send_item(MODE_CPU, 1'b0, 16'hC123, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'h8000, 8'h80);
      send_item(MODE_CPU, 1'b1, 16'h9FFF, 8'hFF);
      send_item(MODE_PPU, 1'b0, 16'h1000, 8'h00);
      send_item(MODE_PPU, 1'b0, 16'hFFFF, 8'h00);
      send_item(MODE_PPU, 1'b1, 16'h0000, 8'hA5);
      send_item(MODE_CPU, 1'b1, 16'hA000, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'hBFFF, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'hA000, 8'h01);
      // latch 2, clear, enable: third tick raises the IRQ
      send_item(MODE_CPU, 1'b1, 16'hC000, 8'h02);
      send_item(MODE_CPU, 1'b1, 16'hDFFF, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'hE001, 8'h00);
      send_item(MODE_TICK, 1'b1, 16'hFFFF, 8'hFF);
      send_item(MODE_TICK, 1'b0, 16'h0000, 8'h00);
      send_item(MODE_TICK, 1'b1, 16'h5A5A, 8'h3C);
      send_item(MODE_ACK, 1'b1, 16'hFFFF, 8'hFF);
      send_item(MODE_CPU, 1'b1, 16'hC000, 8'h00);
      send_item(MODE_TICK, 1'b0, 16'h0000, 8'h00);
      send_item(MODE_CPU, 1'b1, 16'hFFFE, 8'h00);
   endtask

   task automatic send_random();
      int unsigned pick;
      logic [15:0] addr;
      logic [15:0] addr2;
      logic [7:0]  data;
      pick  = $urandom_range(0, 99);
      addr  = 16'($urandom);
      addr2 = 16'($urandom);
      data  = 8'($urandom);
      if (pick < 15) begin
         send_item(MODE_CPU, 1'($urandom_range(0, 1)), addr & 16'h7FFF, data);
      end else if (pick < 30) begin
         send_item(MODE_CPU, 1'b0, addr | 16'h8000, data);
      end else if (pick < 42) begin
         // select then data, the usual bank switch pair
         send_item(MODE_CPU, 1'b1, (addr | 16'h8000) & 16'h9FFE, data);
         send_item(MODE_CPU, 1'b1, (addr2 | 16'h8001) & 16'h9FFF, 8'($urandom));
      end else if (pick < 54) begin
         if ($urandom_range(0, 3) != 0) data = 8'($urandom_range(0, 6));
         send_item(MODE_CPU, 1'b1, 16'hA000 + 16'($urandom_range(0, 16'h5FFF)), data);
      end else if (pick < 72) begin
         send_item(MODE_PPU, 1'($urandom_range(0, 1)), addr, data);
      end else if (pick < 88) begin
         send_item(MODE_TICK, 1'($urandom_range(0, 1)), addr, data);
      end else if (pick < 94) begin
         send_item(MODE_ACK, 1'($urandom_range(0, 1)), addr, data);
      end else begin
         send_item(mode_type'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), addr, data);
      end
   endtask

   initial begin : stimulus
      logic [7:0] prg;
      logic [7:0] chr;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            case (phase)
               1: begin prg = 8'd1;   chr = 8'd0;   end
               2: begin prg = 8'd0;   chr = 8'd7;   end
               3: begin prg = 8'd255; chr = 8'd255; end
               4: begin prg = 8'($urandom_range(2, 254)); chr = 8'd0; end
               default: begin
                  prg = 8'($urandom_range(1, 255));
                  chr = 8'($urandom_range(1, 254));
               end
            endcase
            wait_drained();
            write_config(prg, chr);
         end
         for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
            if (phase == PHASES - 1 && k >= ITEMS_PER_PHASE / 2) calm = 1'b1;
            if (!calm && !hold_on && (sent_count % 64) < 40 && $urandom_range(0, 3) == 0) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 15)) @(posedge clock);
            end
            send_random();
         end
      end
      wait_drained();
      if (check_errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin : receiver
      @(posedge clock);
      forever begin
         if (!pressure_done && sent_count >= PRESSURE_AT) begin
            // long hold-off so the core backs up onto the request side
            pressure_done = 1'b1;
            hold_on       = 1'b1;
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            hold_on = 1'b0;
         end else if (calm) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(0, 2) == 0);
            repeat ($urandom_range(1, 15)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule

@@ bank_switch_mapper_scanline_irq_core.f @@
design/bsm_pkg.sv
design/bsm_banks.sv
design/bank_switch_mapper_scanline_irq_core.sv
tb/sv/bank_switch_mapper_checker.sv
tb/sv/bank_switch_mapper_scanline_irq_core_tb.sv
